### rtl/bmgs_pkg.sv
// Package for the Box-Muller Gaussian sampler: shared types and constants.
// Used by bmgs_front, bmgs_back and box_muller_gaussian_sampler_top.
package bmgs_pkg;

    localparam int ROT_STEPS = 30;
    localparam int LOG_STEPS = 28;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;   // PI_Q60 >> 30, Q2.30
    localparam logic signed [33:0] GAIN_Q30 = 34'sh026DD3B6A;
    // round(2 ln2 * 2^28)
    localparam logic [31:0] TWO_LN2_Q28 = 32'h162E42FF;

    typedef enum logic [2:0] {
        t_IDLE, t_LOG, t_SCALE, t_SQRT, t_ROT, t_MAP, t_MUL, t_OUT
    } t_state;

    // Word handed from the front to the back through the queue.
    typedef struct packed {
        logic signed [31:0] mean;
        logic [31:0]        spread;
        logic [47:0]        u1;
        logic [31:0]        a32;
        logic               cached;
    } t_job;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = 34'sd1;
        endcase
        return v;
    endfunction

endpackage

### rtl/box_muller_gaussian_sampler_top.sv
// Box-Muller Gaussian sampler top level.
// A cached request goes straight to the multiply; a generating one runs 28 log
// squaring steps, the square root, 30 CORDIC steps, then map, multiply and output.
// The back end holds one word at a time and takes the next only once the last has
// gone out, later while the result is stalled; a two-word queue decouples intake.
// Reset (synchronous, active low) empties the queue, clears the cached value and makes the next request generate.
module box_muller_gaussian_sampler_top #(
    parameter int UNIFORM_BITS = 32,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [31:0]      i_mean,
    input  logic [31:0]             i_spread,
    input  logic [UNIFORM_BITS-1:0] i_uniform_radius,
    input  logic [UNIFORM_BITS-1:0] i_uniform_angle,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                    o_from_cache
);
    logic w_jv, w_take;
    bmgs_pkg::t_job w_job;

    bmgs_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_mean(i_mean), .i_spread, .i_uniform_radius, .i_uniform_angle,
        .o_job_valid(w_jv), .o_job(w_job), .i_job_take(w_take)
    );

    bmgs_back #(.UNIFORM_BITS(UNIFORM_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .i_job(w_job), .o_job_take(w_take),
        .o_valid, .i_stall, .o_sample, .o_from_cache
    );
endmodule

### rtl/bmgs_front.sv
// Front end of the sampler: accepts request words, tracks the cache phase,
// drops generating requests with a zero radius word and queues the rest.
// Depends on bmgs_pkg.
module bmgs_front #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [31:0]             i_mean,
    input  logic [31:0]             i_spread,
    input  logic [UNIFORM_BITS-1:0] i_uniform_radius,
    input  logic [UNIFORM_BITS-1:0] i_uniform_angle,
    output logic                    o_job_valid,
    output bmgs_pkg::t_job          o_job,
    input  logic                    i_job_take
);
    // Two-entry queue.
    bmgs_pkg::t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic r_gen_next;   // next request counted for caching phase
    logic [31:0] w_a32;
    logic w_acc, w_push;
    bmgs_pkg::t_job w_job;

    generate
        if (UNIFORM_BITS >= 32) begin : g_wide
            assign w_a32 = i_uniform_angle[UNIFORM_BITS-1 -: 32];
        end else begin : g_narrow
            assign w_a32 = {i_uniform_angle, {(32-UNIFORM_BITS){1'b0}}};
        end
    endgenerate

    assign o_stall = (r_cnt == 2'd2);
    assign w_acc = i_valid && !o_stall;
    assign w_push = w_acc && (r_gen_next || (i_uniform_radius != '0));

    always_comb begin
        w_job = '0;
        w_job.mean = i_mean;
        w_job.spread = i_spread;
        w_job.u1 = 48'(i_uniform_radius);
        w_job.a32 = w_a32;
        w_job.cached = r_gen_next;
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_gen_next <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_job;
                r_wp <= ~r_wp;
                r_gen_next <= ~r_gen_next;
            end
            if (i_job_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_take);
        end
    end
endmodule

### rtl/bmgs_back.sv
// Back end of the sampler: log, sqrt, CORDIC rotation and output scaling
// run one step per cycle on a shared datapath. Depends on bmgs_pkg.
module bmgs_back #(
    parameter int UNIFORM_BITS = 32,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  bmgs_pkg::t_job         i_job,
    output logic                   o_job_take,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_from_cache
);
    localparam int PW = $clog2(UNIFORM_BITS + 1);

    bmgs_pkg::t_state r_st, n_st;
    bmgs_pkg::t_job r_job;
    logic [5:0]  r_cnt;
    logic [31:0] r_m;        // Q2.30 mantissa
    logic [27:0] r_frac;
    logic [PW-1:0] r_k;
    logic [63:0] r_acc;      // cleared during the log, then S<<28, then sqrt remainder
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] r_c, r_s;
    logic signed [31:0] r_cache;
    logic signed [31:0] r_zo;
    logic [1:0] r_phase;     // multiply phase
    logic signed [63:0] r_prod;
    logic r_oval;
    logic [SAMPLE_BITS-1:0] r_osamp;
    logic r_ofc;

    logic w_out_free;
    assign w_out_free = !r_oval || !i_stall;

    // Leading-one search of u1 in the front step of the log.
    logic [PW-1:0] w_p;
    always_comb begin
        w_p = '0;
        for (int j = 0; j < UNIFORM_BITS; j++)
            if (i_job.u1[j]) w_p = PW'(j);
    end

    logic [63:0] w_sq;
    assign w_sq = 64'(r_m) * 64'(r_m);
    logic [33:0] w_mn;
    assign w_mn = 34'(w_sq >> 30);

    logic signed [33:0] w_da;
    assign w_da = bmgs_pkg::atan_q30(r_cnt[4:0]);

    // Saturating narrow of a Q4.28 value.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    logic signed [63:0] w_sum;
    assign w_sum = (r_prod + 64'sd134217728) >>> 28;
    logic signed [63:0] w_fin;
    assign w_fin = w_sum + 64'(r_job.mean);

    always_comb begin
        n_st = r_st;
        case (r_st)
            bmgs_pkg::t_IDLE:  if (i_job_valid)
                                   n_st = i_job.cached ? bmgs_pkg::t_MUL : bmgs_pkg::t_LOG;
            bmgs_pkg::t_LOG:   if (r_cnt == 6'(bmgs_pkg::LOG_STEPS - 1)) n_st = bmgs_pkg::t_SCALE;
            bmgs_pkg::t_SCALE: n_st = bmgs_pkg::t_SQRT;
            bmgs_pkg::t_SQRT:  if (r_bit == 64'd0) n_st = bmgs_pkg::t_ROT;
            bmgs_pkg::t_ROT:   if (r_cnt == 6'(bmgs_pkg::ROT_STEPS - 1)) n_st = bmgs_pkg::t_MAP;
            bmgs_pkg::t_MAP:   if (r_phase == 2'd2) n_st = bmgs_pkg::t_MUL;
            bmgs_pkg::t_MUL:   if (r_phase == 2'd1) n_st = bmgs_pkg::t_OUT;
            bmgs_pkg::t_OUT:   if (w_out_free) n_st = bmgs_pkg::t_IDLE;
            default:           n_st = bmgs_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        o_job_take = (r_st == bmgs_pkg::t_IDLE) && i_job_valid;
    end

    assign o_valid = r_oval;
    assign o_sample = r_osamp;
    assign o_from_cache = r_ofc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bmgs_pkg::t_IDLE;
            r_oval <= 1'b0;
            r_cache <= '0;
            r_cnt <= '0;
            r_phase <= '0;
        end else begin
            r_st <= n_st;
            if (r_oval && !i_stall && r_st != bmgs_pkg::t_OUT) r_oval <= 1'b0;
            case (r_st)
                bmgs_pkg::t_IDLE: begin
                    r_cnt <= '0;
                    r_phase <= '0;
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_frac <= '0;
                        r_k <= PW'(UNIFORM_BITS) - w_p;
                        if (w_p <= PW'(30))
                            r_m <= 32'(i_job.u1 << (PW'(30) - w_p));
                        else
                            r_m <= 32'(i_job.u1 >> (w_p - PW'(30)));
                        r_prod <= 64'(r_cache) * 64'(i_job.spread);
                    end
                end
                bmgs_pkg::t_LOG: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (w_mn[31]) begin
                        r_m <= 32'(w_mn >> 1);
                        r_frac <= {r_frac[26:0], 1'b1};
                    end else begin
                        r_m <= w_mn[31:0];
                        r_frac <= {r_frac[26:0], 1'b0};
                    end
                    r_acc <= '0;
                end
                bmgs_pkg::t_SCALE: begin
                    r_acc <= (((64'(r_k) << 28) - 64'(r_frac)) * 64'(bmgs_pkg::TWO_LN2_Q28)
                              >> 28) << 28;
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                end
                bmgs_pkg::t_SQRT: begin
                    // The cycle that sees the bit run out only hands over to the rotation.
                    if (r_bit != 64'd0) begin
                        if (r_acc >= r_res + r_bit) begin
                            r_acc <= r_acc - (r_res + r_bit);
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                    end
                    r_bit <= r_bit >> 2;
                    r_x <= bmgs_pkg::GAIN_Q30;
                    r_y <= '0;
                    r_z <= 34'sd0 + 34'($signed({1'b0,
                           64'(r_job.a32[29:0]) * 64'(bmgs_pkg::PI_Q30) >> 31}));
                    r_cnt <= '0;
                end
                bmgs_pkg::t_ROT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (!r_z[33]) begin
                        r_x <= r_x - (r_y >>> r_cnt);
                        r_y <= r_y + (r_x >>> r_cnt);
                        r_z <= r_z - w_da;
                    end else begin
                        r_x <= r_x + (r_y >>> r_cnt);
                        r_y <= r_y - (r_x >>> r_cnt);
                        r_z <= r_z + w_da;
                    end
                    r_phase <= '0;
                end
                bmgs_pkg::t_MAP: begin
                    if (r_phase == 2'd0) begin
                        r_phase <= r_phase + 2'd1;
                        case (r_job.a32[31:30])
                            2'd0: begin r_c <= r_x;  r_s <= r_y;  end
                            2'd1: begin r_c <= -r_y; r_s <= r_x;  end
                            2'd2: begin r_c <= -r_x; r_s <= -r_y; end
                            default: begin r_c <= r_y; r_s <= -r_x; end
                        endcase
                    end else if (r_phase == 2'd1) begin
                        r_phase <= r_phase + 2'd1;
                        r_zo <= sat32(($signed({1'b0, r_res[34:0]}) * 64'(r_c)
                                      + 64'sd536870912) >>> 30);
                        r_prod <= ($signed({1'b0, r_res[34:0]}) * 64'(r_s)
                                   + 64'sd536870912) >>> 30;
                    end else begin
                        r_cache <= sat32(r_prod);
                        r_prod <= 64'(r_zo) * 64'(r_job.spread);
                        r_phase <= '0;
                    end
                end
                bmgs_pkg::t_MUL: begin
                    r_phase <= r_phase + 2'd1;
                end
                bmgs_pkg::t_OUT: begin
                    // The result register is loaded only once the previous word has left.
                    if (w_out_free) begin
                        r_oval <= 1'b1;
                        if (w_fin > SMAX) r_osamp <= SMAX[SAMPLE_BITS-1:0];
                        else if (w_fin < SMIN) r_osamp <= SMIN[SAMPLE_BITS-1:0];
                        else r_osamp <= w_fin[SAMPLE_BITS-1:0];
                        r_ofc <= r_job.cached;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
